// ----- design/qwrt_pkg.sv -----
// shared types and constants for the quaternion wrench rotator
// command and status structs between controller and datapath, op codes, widths
// no dependencies
package qwrt_pkg;

    // default widths handed to the top level parameters
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int QUAT_WIDTH_DEF  = 16;

    // fraction bits of the rotation matrix entries, shifted out after each matrix-vector sum
    localparam int RFRAC = 14;

    // silence timeout register and counter
    localparam int              TMO_W   = 16;
    localparam logic [TMO_W-1:0] TMO_RST = 16'd100;

    // op codes carried in tuser
    localparam logic OP_MSG  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // sequencer limits: nine quaternion products, six outputs of three terms
    localparam logic [3:0] QIDX_LAST   = 4'd8;
    localparam logic [2:0] COMP_LAST   = 3'd5;
    localparam logic [2:0] COMP_TORQUE = 3'd3;
    localparam logic [1:0] COL_FIRST   = 2'd0;
    localparam logic [1:0] COL_LAST    = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic       load_msg;
        logic       load_tick;
        logic       qmul_en;
        logic       rbld_en;
        logic       vmul_en;
        logic       load_out;
        logic [3:0] qidx;
        logic [2:0] comp;
        logic [1:0] col;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic tick_timeout;
    } t_sts;

endpackage

// ----- design/qwrt_ctrl.sv -----
// sequencer for the quaternion wrench rotator
// steps the shared multiplier through quaternion products and matrix-vector terms
// depends on qwrt_pkg
module qwrt_ctrl
    import qwrt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_op,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_QMUL  = 3'd1;
    localparam logic [2:0] S_RBLD  = 3'd2;
    localparam logic [2:0] S_VMUL  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state, n_state;
    logic [3:0] r_qidx, n_qidx;
    logic [2:0] r_comp, n_comp;
    logic [1:0] r_col, n_col;
    logic       r_out_vld, n_out_vld;
    logic       in_acc;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_qidx  = r_qidx;
        n_comp  = r_comp;
        n_col   = r_col;
        o_cmd           = '0;
        o_cmd.qidx      = r_qidx;
        o_cmd.comp      = r_comp;
        o_cmd.col       = r_col;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_op == OP_MSG) begin
                        o_cmd.load_msg = 1'b1;
                    end else begin
                        o_cmd.load_tick = 1'b1;
                        n_qidx = '0;
                        n_state = i_sts.tick_timeout ? S_DONE : S_QMUL;
                    end
                end
            end
            S_QMUL: begin
                o_cmd.qmul_en = 1'b1;
                if (r_qidx == QIDX_LAST) begin
                    n_state = S_RBLD;
                end else begin
                    n_qidx = r_qidx + 4'd1;
                end
            end
            S_RBLD: begin
                o_cmd.rbld_en = 1'b1;
                n_comp  = '0;
                n_col   = COL_FIRST;
                n_state = S_VMUL;
            end
            S_VMUL: begin
                o_cmd.vmul_en = 1'b1;
                if (r_col == COL_LAST) begin
                    n_col = COL_FIRST;
                    if (r_comp == COMP_LAST) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_comp = r_comp + 3'd1;
                    end
                end else begin
                    n_col = r_col + 2'd1;
                end
            end
            S_DRAIN: begin
                // last product is summed by the datapath this cycle
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register valid flag
    always_comb begin
        if (o_cmd.load_out) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_qidx    <= '0;
            r_comp    <= '0;
            r_col     <= COL_FIRST;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_qidx    <= n_qidx;
            r_comp    <= n_comp;
            r_col     <= n_col;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

// ----- design/qwrt_dp.sv -----
// datapath of the quaternion wrench rotator
// held wrench, silence counter, shared multiplier, matrix build, accumulator
// depends on qwrt_pkg
module qwrt_dp
    import qwrt_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int QUAT_WIDTH  = QUAT_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_cmd                               i_cmd,
    output t_sts                               o_sts,
    input  logic                               i_cfg_valid,
    input  logic [TMO_W-1:0]                   i_cfg_data,
    input  logic [2:0][VALUE_WIDTH-1:0]        i_force,
    input  logic [2:0][VALUE_WIDTH-1:0]        i_torque,
    input  logic [3:0][QUAT_WIDTH-1:0]         i_quat,
    output logic [5:0][VALUE_WIDTH-1:0]        o_out_data,
    output logic                               o_out_timed
);

    localparam int VW      = VALUE_WIDTH;
    localparam int QW      = QUAT_WIDTH;
    localparam int QF      = QW - 2;
    localparam int RSH_RAW = 2 * QF - RFRAC;
    localparam int RSH     = (RSH_RAW > 0) ? RSH_RAW : 0;
    localparam int RBP     = (RSH > 0) ? RSH - 1 : 0;
    localparam int EW      = 2 * QW + 3;
    localparam int RW      = EW - RSH;
    localparam int PQW     = 2 * QW;
    localparam int MA      = (RW > QW) ? RW : QW;
    localparam int MB      = (VW > QW) ? VW : QW;
    localparam int PW      = MA + MB;
    localparam int RPW     = RW + VW;
    localparam int AW      = RPW + 2;

    localparam logic signed [EW-1:0] E_ONE  = EW'(1) << (2 * QF);
    localparam logic signed [EW-1:0] E_BIAS = (RSH > 0) ? (EW'(1) << RBP) : '0;
    localparam logic signed [AW-1:0] A_BIAS = AW'(1) << (RFRAC - 1);
    localparam logic signed [AW-1:0] A_VMAX = {{(AW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [AW-1:0] A_VMIN = {{(AW-VW+1){1'b1}}, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] V_MAX  = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] V_MIN  = {1'b1, {(VW-1){1'b0}}};

    // quaternion component codes
    localparam logic [1:0] QC_X = 2'd0;
    localparam logic [1:0] QC_Y = 2'd1;
    localparam logic [1:0] QC_Z = 2'd2;
    localparam logic [1:0] QC_W = 2'd3;

    logic signed [VW-1:0]  r_held_f [3];
    logic signed [VW-1:0]  r_held_t [3];
    logic [TMO_W-1:0]      r_ticks;
    logic [TMO_W-1:0]      r_timeout;
    logic                  r_timed;
    logic signed [QW-1:0]  r_quat [4];
    logic signed [PQW-1:0] r_p [9];
    logic signed [RW-1:0]  r_r [3][3];
    logic signed [RPW-1:0] r_prod;
    logic                  r_pv;
    logic [2:0]            r_pcomp;
    logic [1:0]            r_pcol;
    logic signed [AW-1:0]  r_acc;
    logic signed [VW-1:0]  r_res [6];
    logic [5:0][VW-1:0]    r_out;
    logic                  r_out_timed;

    logic [TMO_W-1:0]      ticks_inc;
    logic [1:0]            qa_sel, qb_sel, vrow;
    logic signed [MA-1:0]  mul_a;
    logic signed [MB-1:0]  mul_b;
    logic signed [PW-1:0]  mul_p;
    logic signed [EW-1:0]  pe [9];
    logic signed [EW-1:0]  e [3][3];
    logic signed [AW-1:0]  acc_n, acc_sh;
    logic signed [VW-1:0]  acc_sat;

    // round a matrix entry down to the rotation fraction
    function automatic logic signed [RW-1:0] f_round(input logic signed [EW-1:0] x);
        logic signed [EW-1:0] t;
        t = (x + E_BIAS) >>> RSH;
        return t[RW-1:0];
    endfunction

    // saturating silence counter and timeout compare
    assign ticks_inc        = (r_ticks == '1) ? r_ticks : r_ticks + 1'b1;
    assign o_sts.tick_timeout = (ticks_inc > r_timeout);

    // operand pairs for the nine quaternion products
    always_comb begin
        case (i_cmd.qidx)
            4'd0:    begin qa_sel = QC_X; qb_sel = QC_X; end
            4'd1:    begin qa_sel = QC_Y; qb_sel = QC_Y; end
            4'd2:    begin qa_sel = QC_Z; qb_sel = QC_Z; end
            4'd3:    begin qa_sel = QC_X; qb_sel = QC_Y; end
            4'd4:    begin qa_sel = QC_X; qb_sel = QC_Z; end
            4'd5:    begin qa_sel = QC_Y; qb_sel = QC_Z; end
            4'd6:    begin qa_sel = QC_W; qb_sel = QC_X; end
            4'd7:    begin qa_sel = QC_W; qb_sel = QC_Y; end
            4'd8:    begin qa_sel = QC_W; qb_sel = QC_Z; end
            default: begin qa_sel = QC_X; qb_sel = QC_X; end
        endcase
    end

    // shared multiplier operand selection
    always_comb begin
        vrow = (i_cmd.comp >= COMP_TORQUE) ? 2'(i_cmd.comp - COMP_TORQUE) : i_cmd.comp[1:0];
        if (i_cmd.vmul_en) begin
            mul_a = MA'(r_r[vrow][i_cmd.col]);
            mul_b = (i_cmd.comp >= COMP_TORQUE) ? MB'(r_held_t[i_cmd.col])
                                                : MB'(r_held_f[i_cmd.col]);
        end else begin
            mul_a = MA'(r_quat[qa_sel]);
            mul_b = MB'(r_quat[qb_sel]);
        end
        mul_p = mul_a * mul_b;
    end

    // rotation matrix entries from the registered products
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            pe[k] = EW'(r_p[k]);
        end
        e[0][0] = E_ONE - ((pe[1] + pe[2]) <<< 1);
        e[0][1] = (pe[3] - pe[8]) <<< 1;
        e[0][2] = (pe[4] + pe[7]) <<< 1;
        e[1][0] = (pe[3] + pe[8]) <<< 1;
        e[1][1] = E_ONE - ((pe[0] + pe[2]) <<< 1);
        e[1][2] = (pe[5] - pe[6]) <<< 1;
        e[2][0] = (pe[4] - pe[7]) <<< 1;
        e[2][1] = (pe[5] + pe[6]) <<< 1;
        e[2][2] = E_ONE - ((pe[0] + pe[1]) <<< 1);
    end

    // accumulate three terms, round and saturate
    always_comb begin
        acc_n  = ((r_pcol == COL_FIRST) ? A_BIAS : r_acc) + AW'(r_prod);
        acc_sh = acc_n >>> RFRAC;
        if (acc_sh > A_VMAX) begin
            acc_sat = V_MAX;
        end else if (acc_sh < A_VMIN) begin
            acc_sat = V_MIN;
        end else begin
            acc_sat = acc_sh[VW-1:0];
        end
    end

    // held wrench, counter and timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_held_f[i] <= '0;
                r_held_t[i] <= '0;
            end
            r_ticks   <= '0;
            r_timeout <= TMO_RST;
            r_timed   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
            if (i_cmd.load_msg) begin
                for (int i = 0; i < 3; i++) begin
                    r_held_f[i] <= i_force[i];
                    r_held_t[i] <= i_torque[i];
                end
                r_ticks <= '0;
            end else if (i_cmd.load_tick) begin
                r_ticks <= ticks_inc;
                r_timed <= o_sts.tick_timeout;
            end
        end
    end

    // product pipeline valid flag and output timed flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv        <= 1'b0;
            r_out_timed <= 1'b0;
        end else begin
            r_pv <= i_cmd.vmul_en;
            if (i_cmd.load_out) begin
                r_out_timed <= r_timed;
            end
        end
    end

    // arithmetic payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_tick) begin
            for (int i = 0; i < 4; i++) begin
                r_quat[i] <= i_quat[i];
            end
        end
        if (i_cmd.qmul_en) begin
            r_p[i_cmd.qidx] <= mul_p[PQW-1:0];
        end
        if (i_cmd.rbld_en) begin
            for (int a = 0; a < 3; a++) begin
                for (int b = 0; b < 3; b++) begin
                    r_r[a][b] <= f_round(e[a][b]);
                end
            end
        end
        r_prod  <= mul_p[RPW-1:0];
        r_pcomp <= i_cmd.comp;
        r_pcol  <= i_cmd.col;
        if (r_pv) begin
            r_acc <= acc_n;
            if (r_pcol == COL_LAST) begin
                r_res[r_pcomp] <= acc_sat;
            end
        end
        if (i_cmd.load_out) begin
            for (int i = 0; i < 6; i++) begin
                r_out[i] <= r_timed ? '0 : r_res[i];
            end
        end
    end

    assign o_out_data  = r_out;
    assign o_out_timed = r_out_timed;

endmodule

// ----- design/quaternion_wrench_rotate_with_timeout_top.sv -----
// quaternion wrench rotator, top level: stream ports, controller and datapath
// a message transaction is absorbed in the cycle it is accepted; a tick transaction steps through
// the quaternion products, matrix build, matrix-vector products and drain (straight to done when
// timed out), the single shared multiplier doing 9 quaternion and 18 matrix-vector products; no new
// transaction is taken until its result is loaded; messages are taken while a result waits; synchronous
// active-low reset clears the held wrench, the silence counter and sets the timeout register to 100
module quaternion_wrench_rotate_with_timeout_top
    import qwrt_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int QUAT_WIDTH  = QUAT_WIDTH_DEF,
    localparam int IN_W  = 6 * VALUE_WIDTH + 4 * QUAT_WIDTH,
    localparam int IN_TW = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W  = 6 * VALUE_WIDTH,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // force_x, force_y, force_z, torque_x, torque_y, torque_z, quat_x, quat_y, quat_z, quat_w
    input  logic [IN_TW-1:0]  i_s_axis_tdata,
    // op
    input  logic              i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // world_force_x, world_force_y, world_force_z, world_torque_x, world_torque_y, world_torque_z
    output logic [OUT_TW-1:0] o_m_axis_tdata,
    // timed_out
    output logic              o_m_axis_tuser,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [TMO_W-1:0]  i_cfg_data
);

    localparam int VW = VALUE_WIDTH;
    localparam int QW = QUAT_WIDTH;

    t_cmd                cmd;
    t_sts                sts;
    logic [2:0][VW-1:0]  in_force, in_torque;
    logic [3:0][QW-1:0]  in_quat;
    logic [5:0][VW-1:0]  out_data;
    logic                s_acc;

    // unpack the input transaction
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_force[i]  = i_s_axis_tdata[i * VW +: VW];
            in_torque[i] = i_s_axis_tdata[(3 + i) * VW +: VW];
        end
        for (int i = 0; i < 4; i++) begin
            in_quat[i] = i_s_axis_tdata[6 * VW + i * QW +: QW];
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = OUT_TW'(out_data);
    assign s_acc          = i_s_axis_tvalid && o_s_axis_tready;

    qwrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_op     (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    qwrt_dp #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .QUAT_WIDTH  (QUAT_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_force     (in_force),
        .i_torque    (in_torque),
        .i_quat      (in_quat),
        .o_out_data  (out_data),
        .o_out_timed (o_m_axis_tuser)
    );

    // a timed-out result carries zero vectors
    a_timed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("timed-out result with non-zero vectors");

    // a message never produces a result
    a_msg_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && (i_s_axis_tuser == OP_MSG) && !o_m_axis_tvalid |=> !o_m_axis_tvalid)
        else $error("result appeared after a message");

    // a timed-out tick with a free output register is presented via the done state and the output register
    a_tmo_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && (i_s_axis_tuser == OP_TICK) && sts.tick_timeout && !o_m_axis_tvalid
        |-> ##2 (o_m_axis_tvalid && o_m_axis_tuser))
        else $error("timed-out tick not presented in time");

endmodule
